@@ rtl/capture_timed_uart_receiver_assert.svh @@
// Assertion macros for the capture-timed UART receiver checker.
`ifndef CAPTURE_TIMED_UART_RECEIVER_ASSERT_SVH
`define CAPTURE_TIMED_UART_RECEIVER_ASSERT_SVH

// checked only out of reset
`define CTURX_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// checked during reset as well
`define CTURX_ASSERT_RST(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ rtl/cturx_pkg.sv @@
// Shared types and constants of the capture-timed UART receiver.
package cturx_pkg;

	localparam int TIME_W   = 16;
	localparam int TPB_W    = 13;
	localparam int POS_W    = 4;
	localparam int BYTE_W   = 8;
	localparam int CFG_IDX_W = 2;
	localparam int CFG_DATA_W = 16;
	localparam int OUT_DATA_W = 32;
	localparam int OUT_USER_W = 2;

	localparam logic [POS_W-1:0]  FULL_COUNT = 4'd9;
	localparam logic [POS_W-1:0]  LAST_POS   = 4'd8;
	localparam logic [BYTE_W-1:0] MSB_MARK   = 8'h80;

	localparam logic [TPB_W-1:0]  TPB_RESET  = 13'd139;
	localparam logic [TIME_W-1:0] STOP_RESET = 16'd1285;

	localparam logic [CFG_IDX_W-1:0] REG_TICKS_PER_BIT = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_STOP_TICKS    = 2'd1;

	localparam logic OP_EDGE    = 1'b0;
	localparam logic OP_TIMEOUT = 1'b1;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_EXEC,
		ST_SHIFT,
		ST_FILL,
		ST_RESULT
	} ctrl_state_t;

	typedef struct packed {
		logic load;        // take input beat
		logic begin_item;  // first decode step
		logic shift_step;  // shift one bit, keep going
		logic shift_stop;  // edge before next sample time
		logic shift_done;  // ninth bit shifted by edge
		logic fill_step;   // timeout fill of one bit
		logic fill_done;   // timeout fill complete
		logic emit;        // move result to output register
	} ctrl_cmd_t;

	typedef struct packed {
		logic is_timeout;
		logic pos_zero;
		logic armed;
		logic late;      // capture time not earlier than sample time
		logic last_bit;
		logic full;
		logic out_free;
	} dp_status_t;

	function automatic logic [BYTE_W-1:0] shift_in(input logic [BYTE_W-1:0] cur,
			input logic level);
		shift_in = (cur >> 1) | (level ? MSB_MARK : '0);
	endfunction

endpackage

@@ rtl/cturx_ctrl.sv @@
// Controller state machine of the capture-timed UART receiver.
module cturx_ctrl (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_tvalid,
	output logic                  s_tready,
	input  cturx_pkg::dp_status_t status,
	output cturx_pkg::ctrl_cmd_t  cmd
);
	import cturx_pkg::*;

	ctrl_state_t state_q, state_next;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_next;
		end
	end

	always_comb begin
		state_next = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (s_tvalid) begin
					state_next = ST_EXEC;
				end
			end
			ST_EXEC: begin
				if (!status.is_timeout && !status.pos_zero) begin
					state_next = ST_SHIFT;
				end else if (status.is_timeout && status.armed) begin
					state_next = ST_FILL;
				end else begin
					state_next = ST_RESULT;
				end
			end
			ST_SHIFT: begin
				if (!status.late || status.last_bit) begin
					state_next = ST_RESULT;
				end
			end
			ST_FILL: begin
				if (status.full) begin
					state_next = ST_RESULT;
				end
			end
			ST_RESULT: begin
				if (status.out_free) begin
					state_next = ST_IDLE;
				end
			end
			default: state_next = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd = '0;
		s_tready = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				s_tready = 1'b1;
				cmd.load = s_tvalid;
			end
			ST_EXEC: begin
				cmd.begin_item = 1'b1;
			end
			ST_SHIFT: begin
				if (!status.late) begin
					cmd.shift_stop = 1'b1;
				end else if (status.last_bit) begin
					cmd.shift_done = 1'b1;
				end else begin
					cmd.shift_step = 1'b1;
				end
			end
			ST_FILL: begin
				if (status.full) begin
					cmd.fill_done = 1'b1;
				end else begin
					cmd.fill_step = 1'b1;
				end
			end
			ST_RESULT: begin
				cmd.emit = status.out_free;
			end
			default: begin
				cmd = '0;
			end
		endcase
	end

endmodule

@@ rtl/cturx_dp.sv @@
// Datapath of the capture-timed UART receiver: receiver state, config and output register.
module cturx_dp (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic [cturx_pkg::TIME_W-1:0]          s_tdata,
	input  logic [0:0]                            s_tuser,
	output logic                                  m_tvalid,
	input  logic                                  m_tready,
	output logic [cturx_pkg::OUT_DATA_W-1:0]      m_tdata,
	output logic [cturx_pkg::OUT_USER_W-1:0]      m_tuser,
	input  logic                                  cfg_valid,
	input  logic [cturx_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [cturx_pkg::CFG_DATA_W-1:0]      cfg_data,
	input  cturx_pkg::ctrl_cmd_t                  cmd,
	output cturx_pkg::dp_status_t                 status
);
	import cturx_pkg::*;

	logic [TPB_W-1:0]  tpb_q;
	logic [TIME_W-1:0] stop_q;

	logic              op_q;
	logic [TIME_W-1:0] cap_q;

	logic              line_high_q;
	logic [POS_W-1:0]  pos_q;
	logic [BYTE_W-1:0] shift_q;
	logic [TIME_W-1:0] sample_q;
	logic              armed_q;
	logic [TIME_W-1:0] deadline_q;
	logic [TIME_W-1:0] target_q;

	logic              res_valid_q;
	logic              res_timeout_q;

	logic                  out_valid_q;
	logic [OUT_DATA_W-1:0] out_data_q;
	logic [OUT_USER_W-1:0] out_user_q;

	logic [TIME_W-1:0] tpb_ext;
	logic [TIME_W-1:0] diff;
	logic [BYTE_W-1:0] res_byte;

	assign tpb_ext  = {{(TIME_W-TPB_W){1'b0}}, tpb_q};
	assign diff     = cap_q - target_q;
	assign res_byte = res_valid_q ? shift_q : '0;

	assign status.is_timeout = (op_q == OP_TIMEOUT);
	assign status.pos_zero   = (pos_q == '0);
	assign status.armed      = armed_q;
	assign status.late       = ~diff[TIME_W-1];
	assign status.last_bit   = (pos_q >= LAST_POS);
	assign status.full       = (pos_q >= FULL_COUNT);
	assign status.out_free   = !out_valid_q || m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tpb_q  <= TPB_RESET;
			stop_q <= STOP_RESET;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_TICKS_PER_BIT: tpb_q  <= cfg_data[TPB_W-1:0];
				REG_STOP_TICKS:    stop_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q  <= s_tuser[0];
			cap_q <= s_tdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			line_high_q   <= 1'b0;
			pos_q         <= '0;
			shift_q       <= '0;
			sample_q      <= '0;
			armed_q       <= 1'b0;
			deadline_q    <= '0;
			target_q      <= '0;
			res_valid_q   <= 1'b0;
			res_timeout_q <= 1'b0;
		end else begin
			if (cmd.begin_item) begin
				res_valid_q   <= 1'b0;
				res_timeout_q <= 1'b0;
				target_q      <= sample_q;
				if (op_q == OP_EDGE) begin
					line_high_q <= ~line_high_q;
					if (pos_q == '0 && !line_high_q) begin
						deadline_q <= cap_q + stop_q;
						armed_q    <= 1'b1;
						sample_q   <= cap_q + tpb_ext + (tpb_ext >> 1);
						pos_q      <= 4'd1;
					end
				end else begin
					armed_q <= 1'b0;
				end
			end
			if (cmd.shift_step) begin
				shift_q  <= shift_in(shift_q, line_high_q);
				target_q <= target_q + tpb_ext;
				pos_q    <= pos_q + 4'd1;
			end
			if (cmd.shift_stop) begin
				sample_q <= target_q;
			end
			if (cmd.shift_done) begin
				shift_q     <= shift_in(shift_q, line_high_q);
				armed_q     <= 1'b0;
				res_valid_q <= 1'b1;
				line_high_q <= 1'b0;
				pos_q       <= '0;
			end
			if (cmd.fill_step) begin
				shift_q <= shift_in(shift_q, ~line_high_q);
				pos_q   <= pos_q + 4'd1;
			end
			if (cmd.fill_done) begin
				res_valid_q   <= 1'b1;
				res_timeout_q <= 1'b1;
				line_high_q   <= 1'b0;
				pos_q         <= '0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			out_data_q <= {{(OUT_DATA_W-2*BYTE_W-TIME_W+6){1'b0}}, deadline_q, armed_q,
				line_high_q, res_byte};
			out_user_q <= {res_timeout_q, res_valid_q};
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;
	assign m_tuser  = out_user_q;

endmodule

@@ rtl/capture_timed_uart_receiver.sv @@
// Top level of the capture-timed 8N1 UART receiver.
// Each input beat is a line edge with its 16-bit capture time (tuser 0) or a stop-bit
// timeout (tuser 1); each produces exactly one output beat with the byte, if one
// completed, and the receiver status. An item is loaded, decoded, run through the shift
// or fill loop if needed, and its result moved to the output register: a start edge, a
// rising edge while idle and a timeout while disarmed go straight to the result; a later
// edge shifts bits until the byte completes or the next sample time lies after the edge;
// an armed timeout fills the remaining bits and closes the byte. The shift loop takes one
// bit per cycle. The output register lets a finished result wait while the next input beat
// is taken. Config writes are taken every cycle.
module capture_timed_uart_receiver (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 s_tvalid,
	output logic                                 s_tready,
	input  logic [cturx_pkg::TIME_W-1:0]         s_tdata,   // [15:0] capture_time
	input  logic [0:0]                           s_tuser,   // [0] opcode
	output logic                                 m_tvalid,
	input  logic                                 m_tready,
	// [7:0] data_byte, [8] expect_rising, [9] timeout_armed,
	// [25:10] timeout_deadline, [31:26] zero
	output logic [cturx_pkg::OUT_DATA_W-1:0]     m_tdata,
	output logic [cturx_pkg::OUT_USER_W-1:0]     m_tuser,   // [0] byte_valid, [1] from_timeout
	input  logic                                 cfg_valid,
	output logic                                 cfg_ready,
	input  logic [cturx_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [cturx_pkg::CFG_DATA_W-1:0]     cfg_data
);
	import cturx_pkg::*;

	ctrl_cmd_t  cmd;
	dp_status_t status;

	assign cfg_ready = 1'b1;

	cturx_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.status   (status),
		.cmd      (cmd)
	);

	cturx_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.cfg_valid (cfg_valid),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cmd       (cmd),
		.status    (status)
	);

endmodule

@@ rtl/cturx_chk.sv @@
// Port-level assertion checker for the capture-timed UART receiver, with its bind.
`include "capture_timed_uart_receiver_assert.svh"

module cturx_chk (
	input logic                                 clk,
	input logic                                 arst_n,
	input logic                                 s_tvalid,
	input logic                                 s_tready,
	input logic [cturx_pkg::TIME_W-1:0]         s_tdata,
	input logic [0:0]                           s_tuser,
	input logic                                 m_tvalid,
	input logic                                 m_tready,
	input logic [cturx_pkg::OUT_DATA_W-1:0]     m_tdata,
	input logic [cturx_pkg::OUT_USER_W-1:0]     m_tuser,
	input logic                                 cfg_valid,
	input logic                                 cfg_ready,
	input logic [cturx_pkg::CFG_IDX_W-1:0]      cfg_index,
	input logic [cturx_pkg::CFG_DATA_W-1:0]     cfg_data
);
	import cturx_pkg::*;

	`CTURX_ASSERT_RST(a_no_beat_in_reset, !arst_n |=> !m_tvalid, "output beat during reset")

	`CTURX_ASSERT(a_timeout_needs_byte, (m_tvalid && m_tuser[1]) |-> m_tuser[0], "timeout flag without byte")

	`CTURX_ASSERT(a_byte_disarms, (m_tvalid && m_tuser[0]) |-> (!m_tdata[9] && !m_tdata[8]), "byte delivered while armed or not idle")

	`CTURX_ASSERT(a_no_byte_zero, (m_tvalid && !m_tuser[0]) |-> (m_tdata[7:0] == 8'h00), "data without byte")

	`CTURX_ASSERT(a_out_hold, (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tuser)), "stalled output beat changed")

endmodule

bind capture_timed_uart_receiver cturx_chk u_cturx_chk (.*);

@@ sim/testbench.sv @@
// Self-checking testbench for the capture-timed UART receiver: edge/timeout stream in, status out.
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	import cturx_pkg::*;

	localparam int CYCLE_LIMIT = 2_000_000;
	localparam int ITEM_GOAL = 1650;
	localparam int SETTLE_CYCLES = 20;
	localparam int HOLD_CYCLES = 400;
	localparam int PHASE_ITEMS = 150;
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = 2'd3;

	typedef struct packed {
		logic              op;
		logic [TIME_W-1:0] cap;
	} rx_event_t;

	typedef struct packed {
		logic              valid;
		logic [BYTE_W-1:0] data;
		logic              by_timeout;
		logic              rising;
		logic              armed;
		logic [TIME_W-1:0] deadline;
	} rx_status_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_tvalid = 1'b0;
	logic s_tready;
	logic [TIME_W-1:0] s_tdata = '0;
	logic [0:0] s_tuser = '0;
	logic m_tvalid;
	logic m_tready = 1'b0;
	logic [OUT_DATA_W-1:0] m_tdata;
	logic [OUT_USER_W-1:0] m_tuser;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;

	capture_timed_uart_receiver i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	// receiver shadow: configuration and decode state
	logic [TPB_W-1:0]  cfg_tpb = TPB_RESET;
	logic [TIME_W-1:0] cfg_stop = STOP_RESET;
	logic              line_was_high = 1'b0;
	logic [POS_W-1:0]  bits_taken = '0;
	logic [BYTE_W-1:0] rx_shift = '0;
	logic [TIME_W-1:0] next_sample = '0;
	logic              dl_armed = 1'b0;
	logic [TIME_W-1:0] dl_time = '0;

	rx_event_t  event_queue[$];
	rx_status_t expected_status[$];

	rx_event_t  next_event;
	rx_event_t  taken_event;
	rx_status_t got_status;
	rx_status_t want_status;

	int  items_queued = 0;
	int  beats_in = 0;
	int  ignored_timeouts = 0;
	int  results_seen = 0;
	int  bytes_rx = 0;
	int  bytes_by_timeout = 0;
	int  cfg_writes = 0;
	int  err_cnt = 0;
	bit  in_taken = 1'b0;
	bit  cfg_taken = 1'b0;

	int  gap_left = 0;
	int  burst_left = 0;
	int  hold_left = 0;
	int  next_hold_at = 300;
	int  mode_left = 0;
	int  rdy_mode = 0;
	logic [15:0] rdy_pattern = 16'hFFFF;

	int  frame_tpb = int'(TPB_RESET);
	int  line_clock = 0;
	int  chunk_items = 0;

	initial begin
		forever #5ns clk = ~clk;
	end

	function automatic rx_status_t decode_event(input rx_event_t ev);
		rx_status_t r;
		logic was_high;
		logic fill_level;
		logic [TIME_W-1:0] target;
		logic [TIME_W-1:0] diff;
		logic [POS_W-1:0] pos;
		logic done;
		logic halted;
		int k;
		r = '0;
		done = 1'b0;
		halted = 1'b0;
		if (ev.op == OP_EDGE) begin
			was_high = line_was_high;
			line_was_high = ~was_high;
			if (bits_taken == '0) begin
				if (!was_high) begin
					dl_time = ev.cap + cfg_stop;
					dl_armed = 1'b1;
					next_sample = ev.cap + TIME_W'(cfg_tpb) + TIME_W'(cfg_tpb >> 1);
					bits_taken = 4'd1;
				end
			end else begin
				target = next_sample;
				pos = bits_taken;
				for (k = 0; k < FULL_COUNT && !halted; k++) begin
					diff = ev.cap - target;
					if (diff[TIME_W-1]) begin
						halted = 1'b1;
					end else begin
						rx_shift = {line_was_high, rx_shift[BYTE_W-1:1]};
						target = target + TIME_W'(cfg_tpb);
						pos = pos + 4'd1;
						if (pos >= FULL_COUNT) begin
							done = 1'b1;
							halted = 1'b1;
						end
					end
				end
				if (done) begin
					dl_armed = 1'b0;
					r.valid = 1'b1;
					r.data = rx_shift;
					line_was_high = 1'b0;
					bits_taken = '0;
				end else begin
					next_sample = target;
					bits_taken = pos;
				end
			end
		end else if (dl_armed) begin
			fill_level = ~line_was_high;
			dl_armed = 1'b0;
			pos = bits_taken;
			while (pos < FULL_COUNT) begin
				rx_shift = {fill_level, rx_shift[BYTE_W-1:1]};
				pos = pos + 4'd1;
			end
			r.valid = 1'b1;
			r.by_timeout = 1'b1;
			r.data = rx_shift;
			bits_taken = '0;
			line_was_high = 1'b0;
		end
		r.rising = line_was_high;
		r.armed = dl_armed;
		r.deadline = dl_time;
		return r;
	endfunction

	task automatic report_error(input string msg);
		err_cnt++;
		if (err_cnt <= 10)
			$display("ERROR @%0t: %s", $realtime, msg);
	endtask

	// output beats are checked before a new input beat adds its expectation
	always @(posedge clk) begin
		if (arst_n) begin
			if (m_tvalid && m_tready) begin
				got_status.valid = m_tuser[0];
				got_status.by_timeout = m_tuser[1];
				got_status.data = m_tdata[7:0];
				got_status.rising = m_tdata[8];
				got_status.armed = m_tdata[9];
				got_status.deadline = m_tdata[25:10];
				results_seen++;
				if (expected_status.size() == 0) begin
					report_error($sformatf("unexpected beat %p", got_status));
				end else begin
					want_status = expected_status.pop_front();
					if (want_status.valid)
						bytes_rx++;
					if (want_status.by_timeout)
						bytes_by_timeout++;
					if (got_status !== want_status)
						report_error($sformatf(
							"beat %0d: expected %p, got %p",
							results_seen, want_status, got_status));
				end
			end
			in_taken = s_tvalid && s_tready;
			if (in_taken) begin
				taken_event.op = s_tuser[0];
				taken_event.cap = s_tdata;
				if (taken_event.op == OP_TIMEOUT && !dl_armed)
					ignored_timeouts++;
				expected_status.push_back(decode_event(taken_event));
				beats_in++;
			end
			cfg_taken = cfg_valid && cfg_ready;
			if (cfg_taken) begin
				cfg_writes++;
				if (cfg_index == REG_TICKS_PER_BIT)
					cfg_tpb = cfg_data[TPB_W-1:0];
				else if (cfg_index == REG_STOP_TICKS)
					cfg_stop = cfg_data;
			end
		end
	end

	// sender: bursts of beats with random gaps in between
	always @(negedge clk) begin
		if (arst_n && (!s_tvalid || in_taken)) begin
			if (gap_left > 0) begin
				gap_left--;
				s_tvalid <= 1'b0;
			end else if (event_queue.size() != 0) begin
				next_event = event_queue.pop_front();
				s_tvalid <= 1'b1;
				s_tuser <= next_event.op;
				s_tdata <= next_event.cap;
				if (burst_left > 0) begin
					burst_left--;
				end else begin
					burst_left = $urandom_range(0, 15);
					case ($urandom_range(0, 3))
						0: gap_left = 0;
						1: gap_left = $urandom_range(1, 3);
						2: gap_left = $urandom_range(4, 14);
						default: gap_left = $urandom_range(15, 40);
					endcase
				end
			end else begin
				s_tvalid <= 1'b0;
			end
		end
	end

	// receiver: changing ready patterns, plus long hold-offs to back up the block
	always @(negedge clk) begin
		if (arst_n) begin
			if (hold_left > 0) begin
				hold_left--;
				m_tready <= 1'b0;
			end else if (results_seen >= next_hold_at) begin
				hold_left = HOLD_CYCLES;
				next_hold_at = next_hold_at + 700;
				m_tready <= 1'b0;
			end else begin
				if (mode_left == 0) begin
					mode_left = $urandom_range(20, 120);
					rdy_mode = $urandom_range(0, 3);
					rdy_pattern = 16'($urandom);
				end else begin
					mode_left--;
				end
				case (rdy_mode)
					0: m_tready <= 1'b1;
					1: m_tready <= ($urandom_range(0, 3) != 0);
					2: m_tready <= ($urandom_range(0, 3) == 0);
					default: begin
						m_tready <= rdy_pattern[0];
						rdy_pattern = {rdy_pattern[0], rdy_pattern[15:1]};
					end
				endcase
			end
		end
	end

	task automatic add_event(input logic op, input logic [TIME_W-1:0] cap);
		rx_event_t ev;
		ev.op = op;
		ev.cap = cap;
		event_queue.push_back(ev);
		items_queued++;
	endtask

	// one 8N1 character starting at line_clock; a damaged one loses an edge,
	// gets the wrong timeout decision or picks up a stray edge
	task automatic add_frame(input logic [7:0] value, input bit jitter, input bit damaged);
		logic [9:0] line_bits;
		logic prev;
		bit needs_timeout;
		int k;
		int t;
		int t0;
		int flaw;
		int drop_at;
		t0 = line_clock;
		line_bits = {1'b1, value, 1'b0};
		prev = 1'b1;
		flaw = -1;
		drop_at = -1;
		if (damaged)
			flaw = $urandom_range(0, 2);
		if (flaw == 0)
			drop_at = $urandom_range(0, 9);
		for (k = 0; k < 10; k++) begin
			if (line_bits[k] != prev) begin
				t = t0 + k * frame_tpb;
				if (jitter && k > 0)
					t = t + int'($urandom_range(0, frame_tpb / 2)) - frame_tpb / 4;
				if (k != drop_at)
					add_event(OP_EDGE, t[15:0]);
				prev = line_bits[k];
			end
			if (flaw == 2 && k == 4)
				add_event(OP_EDGE, 16'(t0 + int'($urandom_range(0, 10 * frame_tpb))));
		end
		// no stop edge when the last data bit is already high
		needs_timeout = line_bits[8];
		if (flaw == 1)
			needs_timeout = !needs_timeout;
		if (needs_timeout)
			add_event(OP_TIMEOUT, 16'($urandom));
		line_clock = (t0 + 10 * frame_tpb + int'($urandom_range(0, 3 * frame_tpb + 5)))
			& 32'hFFFF;
	endtask

	task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do
			@(negedge clk);
		while (!cfg_taken);
		cfg_valid <= 1'b0;
		@(negedge clk);
	endtask

	task automatic wait_drained();
		while (beats_in != items_queued || expected_status.size() != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic run_phase(input logic [15:0] tpb_word, input logic [15:0] stop_word,
			input int n_items);
		int goal;
		int pick;
		cfg_write(REG_TICKS_PER_BIT, tpb_word);
		cfg_write(REG_STOP_TICKS, stop_word);
		frame_tpb = int'(tpb_word[TPB_W-1:0]);
		goal = items_queued + n_items;
		while (items_queued < goal) begin
			pick = $urandom_range(0, 99);
			if (pick < 70)
				add_frame(8'($urandom), 1'b1, 1'b0);
			else if (pick < 85)
				add_frame(8'($urandom), 1'b1, 1'b1);
			else if (pick < 93)
				add_event(OP_EDGE, 16'($urandom));
			else
				add_event(OP_TIMEOUT, 16'($urandom));
		end
		wait_drained();
	endtask

	initial begin
		repeat (9) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// directed part, reset configuration
		add_event(OP_TIMEOUT, 16'hFFFF);
		line_clock = 0;
		add_frame(8'h00, 1'b0, 1'b0);
		line_clock = 16'hFFFF;
		add_frame(8'hFF, 1'b0, 1'b0);
		line_clock = 16'h4000;
		add_frame(8'hF0, 1'b0, 1'b0);
		add_event(OP_TIMEOUT, 16'h0000);
		// start edge, then edges exactly on the first and on the last sample point
		add_event(OP_EDGE, 16'd1000);
		add_event(OP_EDGE, 16'd1208);
		add_event(OP_EDGE, 16'd2181);
		// one edge covering many bit times
		add_event(OP_EDGE, 16'd5000);
		add_event(OP_EDGE, 16'd9170);
		// edge half the timer range away reads as earlier than the sample time
		add_event(OP_EDGE, 16'h1000);
		add_event(OP_EDGE, 16'h90D0);
		add_event(OP_TIMEOUT, 16'h5555);
		// start bit only, then timeout
		add_event(OP_EDGE, 16'h2000);
		add_event(OP_TIMEOUT, 16'hAAAA);
		wait_drained();

		run_phase(16'hFFFF, 16'hFFFF, 60);
		cfg_write(REG_SPARE_A, 16'($urandom));
		cfg_write(REG_SPARE_B, 16'hFFFF);
		run_phase(16'd1, 16'd9, 120);
		run_phase(16'd7084, 16'd65535, 80);
		run_phase(16'd0, 16'd0, 60);
		run_phase(16'd139, 16'd1285, 200);
		while (items_queued < ITEM_GOAL) begin
			chunk_items = (ITEM_GOAL - items_queued < PHASE_ITEMS) ?
				ITEM_GOAL - items_queued : PHASE_ITEMS;
			if ($urandom_range(0, 3) == 0) begin
				run_phase(16'($urandom_range(1, 7084)), 16'($urandom_range(9, 65535)),
					chunk_items);
			end else begin
				frame_tpb = $urandom_range(2, 600);
				run_phase(16'(frame_tpb), 16'(frame_tpb * 9 + frame_tpb / 4), chunk_items);
			end
		end

		$display("Run: %0d input beats (%0d timeouts while disarmed), %0d config writes",
			beats_in, ignored_timeouts, cfg_writes);
		$display("     %0d result beats, %0d bytes received, %0d closed by timeout",
			results_seen, bytes_rx, bytes_by_timeout);
		if (err_cnt == 0) begin
			$display("DONE: 0 errors");
		end else begin
			$display("%0d mismatches", err_cnt);
			$display("DONE: errors detected");
		end
		$finish;
	end

	initial begin
		int cycles;
		cycles = 0;
		while (cycles < CYCLE_LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		$display("Timeout after %0d cycles", cycles);
		$display("DONE: errors detected");
		$finish;
	end

endmodule
